// ----- design/addressed_serial_seven_segment_scanner_unit_defines.svh -----
// assertion macros used by the scanner unit design file
`ifndef ADDRESSED_SERIAL_SEVEN_SEGMENT_SCANNER_UNIT_DEFINES_SVH
`define ADDRESSED_SERIAL_SEVEN_SEGMENT_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ASSSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scanner assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define ASSSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scanner assertion failed");

`endif

// ----- design/asss_pkg.sv -----
// types and constants of the serial seven-segment scanner
package asss_pkg;

  // input command codes
  typedef enum logic [1:0] {
    CMD_SHIFT = 2'd0,
    CMD_LATCH = 2'd1,
    CMD_SCAN  = 2'd2
  } cmd_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ADDRESS   = 1'b0,
    REG_ROTATE_PERIOD = 1'b1
  } cfg_reg_e;

  // field widths
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DIGIT_W = 3;
  localparam int unsigned SEG_W   = 8;

  // register reset values
  localparam logic [ADDR_W-1:0]  OWN_ADDRESS_RST   = 16'h0003;
  localparam logic [COUNT_W-1:0] ROTATE_PERIOD_RST = 16'd16384;

  typedef logic [SEG_W-1:0] seg_t;

endpackage

// ----- design/asss_if.sv -----
// valid/ready channel interfaces for scanner input and result transactions
interface asss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       data_level;

  modport source (output valid, output command, output data_level, input ready);
  modport sink   (input valid, input command, input data_level, output ready);
endinterface

interface asss_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] digit_index;
  logic [7:0] segments;

  modport source (output valid, output digit_index, output segments, input ready);
  modport sink   (input valid, input digit_index, input segments, output ready);
endinterface

// ----- design/addressed_serial_seven_segment_scanner_unit.sv -----
// a scan tick transaction gives its result from the output register, in the cycle after acceptance
// throughput: one input transaction per cycle while out_o takes results, set by the single output register
// shift and latch transactions give no result and finish in the accept cycle
// input is stalled only while a result waits in the output register
// reset (async, active low) clears control, chain and address; display store loads its pattern
`include "addressed_serial_seven_segment_scanner_unit_defines.svh"

module addressed_serial_seven_segment_scanner_unit
  import asss_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 48,
  parameter int unsigned DIGITS      = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  asss_in_if.sink              in_i,
  asss_out_if.source           out_o
);

  localparam int unsigned CHAIN_W = STORE_BYTES * SEG_W;
  localparam int unsigned IDX_W   = $clog2(STORE_BYTES);
  localparam int unsigned AMT     = DIGITS % STORE_BYTES;
  localparam logic [IDX_W-1:0]   AMT_IDX    = IDX_W'(AMT);
  localparam logic [DIGIT_W-1:0] DIGIT_LAST = DIGIT_W'(DIGITS - 1);
  localparam logic [IDX_W:0]     BYTES_EXT  = (IDX_W+1)'(STORE_BYTES);

  logic [ADDR_W-1:0]  own_q;
  logic [COUNT_W-1:0] period_q;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [CHAIN_W-1:0] chain_q, chain_d;
  seg_t               store_q [STORE_BYTES];
  seg_t               store_d [STORE_BYTES];
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q;
  logic [DIGIT_W-1:0] out_digit_q;
  seg_t               out_seg_q;

  logic               in_fire, out_fire;
  logic               is_shift, is_latch, is_scan;
  logic               do_latch, do_rotate;
  logic [COUNT_W-1:0] count_inc;
  logic [IDX_W:0]     digit_ext;
  logic [IDX_W-1:0]   mod_idx, rd_idx;
  seg_t               seg_d;

  // handshake: output register doubles as the skid stage
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_valid_q && out_o.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.digit_index = out_digit_q;
  assign out_o.segments    = out_seg_q;

  // command decode
  always_comb begin
    is_shift = 1'b0;
    is_latch = 1'b0;
    is_scan  = 1'b0;
    unique case (cmd_e'(in_i.command))
      CMD_SHIFT: is_shift = in_fire;
      CMD_LATCH: is_latch = in_fire;
      CMD_SCAN:  is_scan  = in_fire;
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q    <= OWN_ADDRESS_RST;
      period_q <= ROTATE_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_OWN_ADDRESS:   own_q    <= cfg_data_i;
        REG_ROTATE_PERIOD: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // serial shift through address and receive chain, top chain bit drops off
  always_comb begin
    addr_d  = addr_q;
    chain_d = chain_q;
    if (is_shift) begin
      addr_d  = {addr_q[ADDR_W-2:0], in_i.data_level};
      chain_d = {chain_q[CHAIN_W-2:0], addr_q[ADDR_W-1]};
    end
  end

  // scan counter and rotation decision, only ahead of digit zero
  assign count_inc = count_q + COUNT_W'(1);
  assign do_rotate = is_scan && (digit_q == '0) && (count_inc == period_q);
  assign do_latch  = is_latch && in_i.data_level && (addr_q == own_q);

  always_comb begin
    count_d = count_q;
    digit_d = digit_q;
    if (is_scan) begin
      if (digit_q == '0) begin
        count_d = do_rotate ? '0 : count_inc;
      end
      digit_d = (digit_q == DIGIT_LAST) ? '0 : digit_q + DIGIT_W'(1);
    end
  end

  // display store: parallel latch from the chain or rotate by one frame
  always_comb begin
    store_d = store_q;
    if (do_latch) begin
      for (int k = 0; k < STORE_BYTES; k++) begin
        store_d[k] = chain_q[k*SEG_W +: SEG_W];
      end
    end else if (do_rotate) begin
      for (int k = 0; k < STORE_BYTES; k++) begin
        store_d[k] = store_q[(k + AMT) % STORE_BYTES];
      end
    end
  end

  // segment read: digit wraps into the store, rotated digit zero reads one frame on
  assign digit_ext = (IDX_W+1)'(digit_q);
  assign mod_idx   = (digit_ext >= BYTES_EXT) ? IDX_W'(digit_ext - BYTES_EXT)
                                              : IDX_W'(digit_ext);
  assign rd_idx    = do_rotate ? AMT_IDX : mod_idx;
  assign seg_d     = store_q[rd_idx];

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      chain_q <= '0;
      digit_q <= '0;
      count_q <= '0;
      for (int k = 0; k < STORE_BYTES; k++) begin
        store_q[k] <= 8'h01 << ((k / DIGITS) % 8);
      end
    end else begin
      addr_q  <= addr_d;
      chain_q <= chain_d;
      digit_q <= digit_d;
      count_q <= count_d;
      store_q <= store_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (is_scan) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_scan) begin
      out_digit_q <= digit_q;
      out_seg_q   <= seg_d;
    end
  end

  // checks on scan sequencing and the serial shift
  `ASSSU_ASSERT_NOW(a_digit_range, 1'b1, digit_q <= DIGIT_LAST)
  `ASSSU_ASSERT_NEXT(a_scan_gives_result, is_scan,
                     out_valid_q && (out_digit_q == $past(digit_q)))
  `ASSSU_ASSERT_NEXT(a_shift_moves_addr, is_shift,
                     (addr_q[0] == $past(in_i.data_level)) &&
                     (addr_q[ADDR_W-1:1] == $past(addr_q[ADDR_W-2:0])))
  `ASSSU_ASSERT_NEXT(a_rotate_clears_count, do_rotate, count_q == '0)

endmodule
